[hw/rtl/ndcg_pkg.sv]
// Shared constants, state encoding and the discount table function of the NDCG scorer.
`default_nettype none

package ndcg_pkg;

   localparam int GRADE_W = 4;
   localparam int SCORE_W = 17;
   localparam int DISC_W  = 17;
   localparam int SUM_W   = 40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_ADD,
      ST_WALK,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Discount 1/log2(p+2) in Q1.16, rounded to nearest with ties upward.
   // The log2 is taken bit by bit through repeated squaring, truncated to Q.16.
   function automatic logic [DISC_W-1:0] disc_of(input int p);
      logic [31:0] n;
      logic [31:0] t;
      logic [31:0] k;
      logic [31:0] log_q;
      logic [63:0] x;
      logic [63:0] l;
      logic [63:0] num;
      logic [63:0] rem;
      logic [33:0] quo;
      n = 32'(p + 2);
      t = n;
      k = '0;
      while (t > 32'd1) begin
         t = t >> 1;
         k = k + 32'd1;
      end
      x = 64'(n) << (32'd30 - k);
      log_q = k << 16;
      for (int i = 15; i >= 0; i--) begin
         x = (x * x) >> 30;
         if (x >= 64'h8000_0000) begin
            x = x >> 1;
            log_q[i] = 1'b1;
         end
      end
      l = 64'(log_q);
      num = (64'd1 << 32) + (l >> 1);
      rem = '0;
      quo = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= l) begin
            rem = rem - l;
            quo[i] = 1'b1;
         end
      end
      return DISC_W'(quo);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ndcg_req_if.sv]
// Ready/valid channel that carries one ranked grade item into the scorer.
`default_nettype none

interface ndcg_req_if;
   import ndcg_pkg::*;

   logic               valid;
   logic               ready;
   logic [GRADE_W-1:0] grade;
   logic               is_last;

   modport source (output valid, output grade, output is_last, input ready);
   modport sink   (input valid, input grade, input is_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/ndcg_rsp_if.sv]
// Ready/valid channel that carries one list score item out of the scorer.
`default_nettype none

interface ndcg_rsp_if;
   import ndcg_pkg::*;

   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic               overflowed;

   modport source (output valid, output score, output overflowed, input ready);
   modport sink   (input valid, input score, input overflowed, output ready);
endinterface

`default_nettype wire

[hw/rtl/ndcg_divider.sv]
// Restoring divider that produces one quotient bit of DCG/IDCG per cycle.
`default_nettype none

module ndcg_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ndcg_pkg::SUM_W-1:0]    dividend,
   input  logic [ndcg_pkg::SUM_W-1:0]    divisor,
   output logic [FRAC_BITS-1:0]          quotient,
   output logic                          done
);
   import ndcg_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;

   logic [SUM_W:0]       shifted;
   logic [SUM_W:0]       diff;
   logic                 fits;

   // The partial remainder stays below the divisor, so its double fits in SUM_W+1 bits.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_BITS);
         rem_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
         quo_in = {quo_ff[FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

[hw/rtl/ndcg_list_scorer.sv]
// Top level of the NDCG list scorer: load sequencer, ideal-ranking walk and score output.
`default_nettype none

// A list loads one item at a time: the item is taken, its gain times
// discount is formed by a shift and subtract, and the next item is taken while
// that term is added into the saturating DCG sum. One term unit and one adder
// serve both the DCG and the ideal DCG. On the last item the histogram of grades
// is walked from MAX_GRADE down, each counted item passing through the same term
// and add steps, then DCG is compared with IDCG and divided bit-serially
// (skipped when DCG is zero or not below IDCG), and the result is loaded into the
// output register. The score waits there until taken, and the next list can
// start loading meanwhile. Items beyond MAX_DOCS are dropped and flagged.
module ndcg_list_scorer #(
   parameter int MAX_DOCS        = 64,
   parameter int MAX_GRADE       = 15,
   parameter int SCORE_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   ndcg_req_if.sink          req_chan,
   ndcg_rsp_if.source        rsp_chan
);
   import ndcg_pkg::*;

   localparam int POS_W  = $clog2(MAX_DOCS + 1);
   localparam int IDX_W  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
   localparam int GR_W   = (MAX_GRADE > 1) ? $clog2(MAX_GRADE + 1) : 1;
   localparam int CMP_W  = (GR_W > GRADE_W) ? GR_W : GRADE_W;
   localparam int TERM_W = DISC_W + MAX_GRADE;
   localparam int ADD_W  = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;
   localparam int Q_W    = SCORE_FRAC_BITS + 1;

   logic [DISC_W-1:0] disc_rom [MAX_DOCS];

   for (genvar i = 0; i < MAX_DOCS; i++) begin : g_disc
      assign disc_rom[i] = disc_of(i);
   end

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [SUM_W-1:0]   dcg_ff, dcg_in;
   logic [SUM_W-1:0]   idcg_ff, idcg_in;
   logic [POS_W-1:0]   hist_ff [MAX_GRADE+1];
   logic [POS_W-1:0]   hist_in [MAX_GRADE+1];
   logic               overflow_ff, overflow_in;
   logic               last_ff, last_in;
   logic               walk_ff, walk_in;
   logic [GR_W-1:0]    walk_g_ff, walk_g_in;
   logic [GR_W-1:0]    g_ff, g_in;
   logic [DISC_W-1:0]  disc_ff, disc_in;
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [Q_W-1:0]     res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CMP_W-1:0]   grade_ext;
   logic [GR_W-1:0]    grade_sat;
   logic               accept;
   logic               keep;
   logic [GR_W-1:0]    hist_idx;
   logic [POS_W-1:0]   hist_cur;
   logic               grade_empty;
   logic [DISC_W-1:0]  disc_sel;
   logic [SUM_W-1:0]   acc_sel;
   logic [ADD_W-1:0]   sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic [TERM_W-1:0]  term_calc;
   logic               out_free;
   logic               trivial;

   logic               req_ready;
   logic               start_walk;
   logic               div_start;
   logic [SCORE_FRAC_BITS-1:0] div_q;
   logic               div_done;

   ndcg_divider #(
      .FRAC_BITS (SCORE_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dcg_ff),
      .divisor  (idcg_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   always_comb begin
      grade_ext   = CMP_W'(req_chan.grade);
      grade_sat   = (grade_ext > CMP_W'(MAX_GRADE)) ? GR_W'(MAX_GRADE) : GR_W'(grade_ext);
      accept      = req_chan.valid && req_ready;
      keep        = position_ff < POS_W'(MAX_DOCS);
      hist_idx    = (state_ff == ST_WALK) ? walk_g_ff : grade_sat;
      hist_cur    = hist_ff[hist_idx];
      grade_empty = hist_cur == '0;
      disc_sel    = disc_rom[position_ff[IDX_W-1:0]];
      acc_sel     = walk_ff ? idcg_ff : dcg_ff;
      sum_wide    = ADD_W'(acc_sel) + ADD_W'(term_ff);
      sum_sat     = (sum_wide[ADD_W-1:SUM_W] != '0) ? '1 : sum_wide[SUM_W-1:0];
      // Gain 2^g - 1 times the discount is the discount shifted by g, less itself.
      term_calc   = (TERM_W'(disc_ff) << g_ff) - TERM_W'(disc_ff);
      out_free    = !rsp_valid_ff || rsp_chan.ready;
      trivial     = (dcg_ff == '0) || (dcg_ff >= idcg_ff);
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE) ||
                   ((state_ff == ST_ADD) && !walk_ff && !last_ff);
      start_walk = (accept && !keep && req_chan.is_last) ||
                   ((state_ff == ST_ADD) && !walk_ff && !accept && last_ff);
      div_start  = (state_ff == ST_CHECK) && !trivial;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_ADD: begin
            if (state_ff == ST_ADD && walk_ff) begin
               state_in = ST_WALK;
            end else if (accept) begin
               if (keep) begin
                  state_in = ST_TERM;
               end else if (req_chan.is_last) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (state_ff == ST_ADD) begin
               state_in = last_ff ? ST_WALK : ST_IDLE;
            end
         end
         ST_TERM: begin
            state_in = ST_ADD;
         end
         ST_WALK: begin
            if (!grade_empty) begin
               state_in = ST_TERM;
            end else if (walk_g_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = trivial ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      position_in  = position_ff;
      dcg_in       = dcg_ff;
      idcg_in      = idcg_ff;
      hist_in      = hist_ff;
      overflow_in  = overflow_ff;
      last_in      = last_ff;
      walk_in      = walk_ff;
      walk_g_in    = walk_g_ff;
      g_in         = g_ff;
      disc_in      = disc_ff;
      term_in      = term_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      score_in     = score_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         last_in = req_chan.is_last;
         if (keep) begin
            disc_in           = disc_sel;
            g_in              = grade_sat;
            hist_in[hist_idx] = hist_cur + POS_W'(1);
            position_in       = position_ff + POS_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (start_walk) begin
         walk_in     = 1'b1;
         position_in = '0;
         walk_g_in   = GR_W'(MAX_GRADE);
      end

      case (state_ff)
         ST_TERM: begin
            term_in = term_calc;
         end
         ST_ADD: begin
            if (walk_ff) begin
               idcg_in = sum_sat;
            end else begin
               dcg_in = sum_sat;
            end
         end
         ST_WALK: begin
            // Each counted item of the current grade takes the next ideal position.
            if (!grade_empty) begin
               disc_in           = disc_sel;
               g_in              = walk_g_ff;
               hist_in[hist_idx] = hist_cur - POS_W'(1);
               position_in       = position_ff + POS_W'(1);
            end else if (walk_g_ff != '0) begin
               walk_g_in = walk_g_ff - GR_W'(1);
            end
         end
         ST_CHECK: begin
            if (dcg_ff == '0) begin
               res_in = '0;
            end else if (dcg_ff >= idcg_ff) begin
               res_in = Q_W'(1) << SCORE_FRAC_BITS;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in = Q_W'(div_q);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               score_in     = SCORE_W'(res_ff);
               rsp_ovf_in   = overflow_ff;
               position_in  = '0;
               dcg_in       = '0;
               idcg_in      = '0;
               overflow_in  = 1'b0;
               last_in      = 1'b0;
               walk_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         dcg_ff       <= '0;
         idcg_ff      <= '0;
         overflow_ff  <= 1'b0;
         last_ff      <= 1'b0;
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= MAX_GRADE; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         dcg_ff       <= dcg_in;
         idcg_ff      <= idcg_in;
         overflow_ff  <= overflow_in;
         last_ff      <= last_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
      walk_g_ff  <= walk_g_in;
      g_ff       <= g_in;
      disc_ff    <= disc_in;
      term_ff    <= term_in;
      res_ff     <= res_in;
      score_ff   <= score_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.score      = score_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire
